[src/mme_pkg.sv]
`default_nettype none
package mme_pkg;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CAP_W   = 16;

	localparam logic [0:0] REG_UNLIMITED = 1'b0;
	localparam logic [0:0] REG_CAPACITY  = 1'b1;

	localparam logic [4:0] FN_NOTE_OFF   = 5'd0;
	localparam logic [4:0] FN_NOTE_ON    = 5'd1;
	localparam logic [4:0] FN_POLY_PRESS = 5'd2;
	localparam logic [4:0] FN_CONTROL    = 5'd3;
	localparam logic [4:0] FN_PROGRAM    = 5'd4;
	localparam logic [4:0] FN_CHAN_PRESS = 5'd5;
	localparam logic [4:0] FN_BEND       = 5'd6;
	localparam logic [4:0] FN_QFRAME     = 5'd7;
	localparam logic [4:0] FN_SONG_POS   = 5'd8;
	localparam logic [4:0] FN_SONG_SEL   = 5'd9;
	localparam logic [4:0] FN_TUNE       = 5'd10;
	localparam logic [4:0] FN_CLOCK      = 5'd11;
	localparam logic [4:0] FN_START      = 5'd12;
	localparam logic [4:0] FN_CONTINUE   = 5'd13;
	localparam logic [4:0] FN_STOP       = 5'd14;
	localparam logic [4:0] FN_SENSE      = 5'd15;
	localparam logic [4:0] FN_RESET      = 5'd16;
	localparam logic [4:0] FN_SYSEX      = 5'd17;

	localparam logic [7:0] SOX_BYTE  = 8'hF0;
	localparam logic [7:0] EOX_BYTE  = 8'hF7;
	localparam logic [7:0] SYS_BASE  = 8'hF1;
	localparam logic [7:0] HI_MASK   = 8'hF0;
	localparam logic [7:0] LO_MASK   = 8'h0F;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;

	typedef struct packed {
		logic [4:0]  func;
		logic [3:0]  channel;
		logic [7:0]  value_a;
		logic [7:0]  value_b;
		logic [15:0] wide_value;
		logic [11:0] sysex_length;
		logic        sysex_first;
		logic        sysex_last;
		logic        sysex_has_byte;
		logic [7:0]  sysex_byte;
	} msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic [2:0][7:0] byts;
		logic [1:0]      cnt;
		logic            bval;
		logic [1:0]      status;
	} desc_t;

	typedef struct packed {
		logic push;
	} qctl_t;

	function automatic logic [7:0] sys_status(input logic [4:0] f);
		logic [7:0] s;
		case (f)
			FN_TUNE:     s = 8'hF6;
			FN_CLOCK:    s = 8'hF8;
			FN_START:    s = 8'hFA;
			FN_CONTINUE: s = 8'hFB;
			FN_STOP:     s = 8'hFC;
			FN_SENSE:    s = 8'hFE;
			FN_RESET:    s = 8'hFF;
			default:     s = 8'hFF;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[src/mme_ifs.sv]
`default_nettype none
interface mme_msg_if import mme_pkg::*; ();
	logic valid;
	logic ready;
	msg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mme_res_if import mme_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/mme_front.sv]
`default_nettype none
module mme_front import mme_pkg::*; #(
	parameter int unsigned MAX_SYSEX_LEN = 4095
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	mme_msg_if.sink               msg,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	output qctl_t                 qctl,
	input  wire logic             q_full,
	output desc_t                 desc
);

	localparam logic [CAP_W-1:0] MAX_LEN = CAP_W'(MAX_SYSEX_LEN);

	logic             unl_q;
	logic [CAP_W-1:0] rem_q;
	logic             drop_q;

	logic             acc;
	logic [CAP_W-1:0] len;
	logic [CAP_W-1:0] slen;
	logic             fits;
	logic             charge;
	logic             drop_nxt;
	logic [1:0]       n;
	logic [2:0][7:0]  b;
	msg_t             m;

	assign m     = msg.data;
	assign acc   = msg.valid && !q_full;
	assign msg.ready = !q_full;
	assign qctl.push = acc;

	always_comb begin
		b        = '0;
		n        = 2'd0;
		len      = '0;
		slen     = {4'b0, m.sysex_length};
		charge   = 1'b0;
		drop_nxt = drop_q;
		desc     = '0;
		if (slen > MAX_LEN) begin
			slen = MAX_LEN;
		end
		if (m.func == FN_SYSEX) begin
			if (m.sysex_first) begin
				len = slen + CAP_W'(2);
			end
			fits = unl_q || (rem_q >= len);
			if (m.sysex_first) begin
				charge   = fits;
				drop_nxt = !fits;
			end
			if (m.sysex_first) begin
				b[n] = SOX_BYTE;
				n    = n + 2'd1;
			end
			if (m.sysex_has_byte) begin
				b[n] = {1'b0, m.sysex_byte[6:0]};
				n    = n + 2'd1;
			end
			if (m.sysex_last) begin
				b[n] = EOX_BYTE;
				n    = n + 2'd1;
			end
			if (drop_nxt) begin
				if (m.sysex_last) begin
					drop_nxt = 1'b0;
				end
				desc.cnt    = 2'd1;
				desc.status = ST_NO_SPACE;
			end else if (n == 2'd0) begin
				desc.cnt    = 2'd1;
				desc.status = ST_OK;
			end else begin
				desc.byts = b;
				desc.cnt  = n;
				desc.bval = 1'b1;
			end
		end else if (m.func > FN_RESET) begin
			fits        = 1'b1;
			desc.cnt    = 2'd1;
			desc.status = ST_BAD_TYPE;
		end else begin
			case (m.func)
				FN_NOTE_OFF, FN_NOTE_ON, FN_POLY_PRESS, FN_CONTROL, FN_PROGRAM,
				FN_CHAN_PRESS, FN_BEND:
					b[0] = ({1'b1, m.func[2:0], 4'b0} & HI_MASK) | ({4'b0, m.channel} & LO_MASK);
				FN_QFRAME, FN_SONG_POS, FN_SONG_SEL:
					b[0] = SYS_BASE + {3'b0, m.func - FN_QFRAME};
				default:
					b[0] = sys_status(m.func);
			endcase
			case (m.func)
				FN_NOTE_OFF, FN_NOTE_ON, FN_POLY_PRESS, FN_CONTROL: begin
					b[1] = {1'b0, m.value_a[6:0]};
					b[2] = {1'b0, m.value_b[6:0]};
					n    = 2'd3;
				end
				FN_PROGRAM, FN_QFRAME, FN_SONG_SEL: begin
					b[1] = {1'b0, m.value_a[6:0]};
					n    = 2'd2;
				end
				FN_CHAN_PRESS: begin
					b[1] = {1'b0, m.value_b[6:0]};
					n    = 2'd2;
				end
				FN_BEND, FN_SONG_POS: begin
					b[1] = {1'b0, m.wide_value[6:0]};
					b[2] = {1'b0, m.wide_value[13:7]};
					n    = 2'd3;
				end
				default: n = 2'd1;
			endcase
			len    = {{(CAP_W-2){1'b0}}, n};
			fits   = unl_q || (rem_q >= len);
			charge = fits;
			if (fits) begin
				desc.byts = b;
				desc.cnt  = n;
				desc.bval = 1'b1;
			end else begin
				desc.cnt    = 2'd1;
				desc.status = ST_NO_SPACE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unl_q  <= 1'b1;
			rem_q  <= '0;
			drop_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_UNLIMITED: unl_q <= cfg_wdata[0];
					REG_CAPACITY:  rem_q <= cfg_wdata[CAP_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				if (m.func == FN_SYSEX) begin
					drop_q <= drop_nxt;
				end
				if (charge && !unl_q) begin
					rem_q <= rem_q - len;
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/mme_queue.sv]
`default_nettype none
module mme_queue import mme_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire qctl_t qctl,
	input  wire desc_t wr_desc,
	output logic       full,
	output logic       head_valid,
	output desc_t      head,
	input  wire logic  pop
);

	desc_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rp_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (qctl.push) begin
			mem_q[wp_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (qctl.push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, qctl.push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

[src/mme_back.sv]
`default_nettype none
module mme_back import mme_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire desc_t head,
	output logic       pop,
	mme_res_if.source  bytes
);

	logic [1:0] idx_q;
	logic       vld_q;
	res_t       res_q;
	logic       load;
	logic       is_last;

	assign load    = head_valid && (!vld_q || bytes.ready);
	assign is_last = idx_q == (head.cnt - 2'd1);
	assign pop     = load && is_last;

	assign bytes.valid = vld_q;
	assign bytes.data  = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte   <= head.byts[idx_q];
			res_q.byte_valid <= head.bval;
			res_q.last       <= is_last;
			res_q.status     <= head.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (bytes.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[src/midi_message_encoder_core.sv]
`default_nettype none
// Channel   Dir   Carries
// msg       in    one MIDI message, or one sysex item: an optional data byte with its marks
// bytes     out   one wire byte or status per item, last marks the end of each msg item
// cfg_*     in    register writes: 0 unlimited mode, 1 capacity (reloads budget)
//
// Front takes one message per cycle while the queue is not full; back sends one byte per cycle while bytes is ready.
// A message of n bytes (1 to 3) holds the back until its last byte is sent.
// Two-entry queue between them; front stalls only while it is full.
// Reset: unlimited mode on, budget zero, no sysex being dropped.
module midi_message_encoder_core import mme_pkg::*; #(
	parameter int unsigned MAX_SYSEX_LEN = 4095
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	mme_msg_if.sink               msg,
	mme_res_if.source             bytes,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_idx,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	qctl_t qctl;
	desc_t wr_desc;
	desc_t head;
	logic  q_full;
	logic  head_valid;
	logic  pop;

	mme_front #(.MAX_SYSEX_LEN(MAX_SYSEX_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.qctl      (qctl),
		.q_full    (q_full),
		.desc      (wr_desc)
	);

	mme_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.qctl       (qctl),
		.wr_desc    (wr_desc),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	mme_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.bytes      (bytes)
	);

endmodule
`default_nettype wire
